@@ hw/rtl/ufh_pkg.sv @@
// shared types, response codes and response byte table for the upgrade frame handler
`timescale 1ns / 1ps

package ufh_pkg;

    localparam int HDR_LEN = 11;

    // response selected at frame end
    localparam logic [1:0] RESP_NONE = 2'd0;
    localparam logic [1:0] RESP_INFO = 2'd1;
    localparam logic [1:0] RESP_DATA = 2'd2;
    localparam logic [1:0] RESP_CMD4 = 2'd3;

    // frame commands in header byte 0
    localparam logic [7:0] CMD_INFO = 8'h02;
    localparam logic [7:0] CMD_DATA = 8'h03;
    localparam logic [7:0] CMD_CMD4 = 8'h04;

    // targets in header byte 5
    localparam logic [7:0] TGT_TBOX = 8'h01;
    localparam logic [7:0] TGT_MCU  = 8'h02;

    typedef struct packed {
        logic [1:0]  resp;
        logic        cpl;
        logic        tgt;
        logic [31:0] size;
        logic [7:0]  sel;
    } job_t;

    function automatic logic [2:0] resp_last_idx(input logic [1:0] resp);
        logic [2:0] r;
        case (resp)
            RESP_INFO: r = 3'd6;
            RESP_DATA: r = 3'd7;
            RESP_CMD4: r = 3'd5;
            default:   r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] resp_byte(input logic [1:0] resp, input logic [2:0] idx,
                                             input logic [7:0] sel);
        logic [7:0] b;
        b = 8'h00;
        case (resp)
            RESP_INFO:
            begin
                case (idx)
                    3'd0:    b = 8'h12;
                    3'd4:    b = 8'h01;
                    3'd6:    b = 8'h13;
                    default: b = 8'h00;
                endcase
            end
            RESP_DATA:
            begin
                case (idx)
                    3'd0:    b = 8'h13;
                    3'd4:    b = 8'h02;
                    3'd6:    b = sel;
                    3'd7:    b = sel ^ 8'h11;
                    default: b = 8'h00;
                endcase
            end
            RESP_CMD4:
            begin
                case (idx)
                    3'd0:    b = 8'h14;
                    3'd4:    b = 8'h01;
                    3'd5:    b = 8'h15;
                    default: b = 8'h00;
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ hw/rtl/upgrade_frame_handler.sv @@
// top level of the upgrade frame handler: frame receiver and result sequencing
//
// channel   signals                                               direction
// in        in_valid, in_stall, rx_byte, rx_last                  bytes in
// out       out_valid, out_stall, result_kind, tx_byte, tx_last,  results out
//           image_target, image_size
//
// one frame byte is taken per cycle while in_stall is low; header capture,
// xor check and the total update happen in the cycle a byte is taken
// a frame end with an answer loads the sequencer, which sends one result per
// cycle (up to 9); in_stall stays high until the last result is loaded
// results wait in a single output register while out_stall is high
// rst_n clears frame state, stored sizes and the received total
`timescale 1ns / 1ps

module upgrade_frame_handler
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        rx_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [7:0]  tx_byte,
    output logic        tx_last,
    output logic        image_target,
    output logic [31:0] image_size
);
    import ufh_pkg::*;

    logic [3:0]  pos_reg;
    logic [7:0]  xor_reg;
    logic [7:0]  hdr_reg [HDR_LEN];
    logic [31:0] tbox_size_reg;
    logic [31:0] mcu_size_reg;
    logic [31:0] total_reg;

    logic [7:0]  hdr_cur [HDR_LEN];
    logic [7:0]  xor_cur;
    logic [31:0] info_size;
    logic [31:0] data_len;
    logic [31:0] total_sum;
    logic        accept;
    logic        frame_ok;
    logic        tgt_tbox;
    logic        tgt_mcu;
    logic        job_load;
    logic        busy;
    job_t        job;

    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    always_comb
    begin
        for (int i = 0; i < HDR_LEN; i++)
        begin
            hdr_cur[i] = (pos_reg == 4'(i)) ? rx_byte : hdr_reg[i];
        end
    end

    assign xor_cur   = xor_reg ^ rx_byte;
    assign frame_ok  = (xor_cur == 8'h00);
    assign tgt_tbox  = (hdr_cur[5] == TGT_TBOX);
    assign tgt_mcu   = (hdr_cur[5] == TGT_MCU);
    assign info_size = {hdr_cur[6], hdr_cur[7], hdr_cur[8], hdr_cur[9]};
    assign data_len  = {hdr_cur[1], hdr_cur[2], hdr_cur[3], hdr_cur[4]};
    assign total_sum = total_reg + data_len - 32'd2;

    always_comb
    begin
        job      = '0;
        job.sel  = hdr_cur[6];
        job_load = 1'b0;
        if (accept && rx_last && frame_ok)
        begin
            unique case (hdr_cur[0])
                CMD_INFO:
                begin
                    job.resp = RESP_INFO;
                    job_load = 1'b1;
                end
                CMD_DATA:
                begin
                    job.resp = RESP_DATA;
                    job_load = 1'b1;
                    if (tgt_tbox && total_sum == tbox_size_reg)
                    begin
                        job.resp = RESP_NONE;
                        job.cpl  = 1'b1;
                        job.tgt  = 1'b0;
                        job.size = tbox_size_reg;
                    end
                    else if (tgt_mcu && total_sum == mcu_size_reg)
                    begin
                        job.cpl  = 1'b1;
                        job.tgt  = 1'b1;
                        job.size = mcu_size_reg;
                    end
                end
                CMD_CMD4:
                begin
                    job.resp = RESP_CMD4;
                    job_load = 1'b1;
                end
                default:
                begin
                    job_load = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 4'd0;
            xor_reg       <= 8'h00;
            tbox_size_reg <= 32'd0;
            mcu_size_reg  <= 32'd0;
            total_reg     <= 32'd0;
            for (int i = 0; i < HDR_LEN; i++)
            begin
                hdr_reg[i] <= 8'h00;
            end
        end
        else if (accept)
        begin
            if (rx_last)
            begin
                pos_reg <= 4'd0;
                xor_reg <= 8'h00;
                for (int i = 0; i < HDR_LEN; i++)
                begin
                    hdr_reg[i] <= 8'h00;
                end
                if (frame_ok && hdr_cur[0] == CMD_INFO)
                begin
                    if (tgt_tbox)
                    begin
                        tbox_size_reg <= info_size;
                    end
                    else if (tgt_mcu)
                    begin
                        mcu_size_reg <= info_size;
                    end
                end
                if (frame_ok && hdr_cur[0] == CMD_DATA && (tgt_tbox || tgt_mcu))
                begin
                    total_reg <= total_sum;
                end
            end
            else
            begin
                xor_reg <= xor_cur;
                for (int i = 0; i < HDR_LEN; i++)
                begin
                    hdr_reg[i] <= hdr_cur[i];
                end
                // position saturates past the header
                if (pos_reg < 4'(HDR_LEN))
                begin
                    pos_reg <= pos_reg + 4'd1;
                end
            end
        end
    end

    ufh_tx_seq u_tx_seq
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_load     (job_load),
        .job          (job),
        .busy         (busy),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .tx_byte      (tx_byte),
        .tx_last      (tx_last),
        .image_target (image_target),
        .image_size   (image_size)
    );

endmodule

@@ hw/rtl/ufh_tx_seq.sv @@
// response sequencer and result register of the upgrade frame handler
`timescale 1ns / 1ps

module ufh_tx_seq
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         job_load,
    input  ufh_pkg::job_t job,
    output logic         busy,
    output logic         out_valid,
    input  logic         out_stall,
    output logic         result_kind,
    output logic [7:0]   tx_byte,
    output logic         tx_last,
    output logic         image_target,
    output logic [31:0]  image_size
);
    import ufh_pkg::*;

    logic        busy_reg, busy_next;
    job_t        job_reg, job_next;
    logic [2:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    logic        kind_reg, kind_next;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg, last_next;
    logic        tgt_reg, tgt_next;
    logic [31:0] size_reg, size_next;
    logic        emit;

    // result register is free when empty or its item is taken this cycle
    assign emit = busy_reg && (!out_valid_reg || !out_stall);

    always_comb
    begin
        busy_next      = busy_reg;
        job_next       = job_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        tgt_next       = tgt_reg;
        size_next      = size_reg;
        if (job_load)
        begin
            busy_next = 1'b1;
            job_next  = job;
            idx_next  = 3'd0;
        end
        else if (emit)
        begin
            out_valid_next = 1'b1;
            if (job_reg.cpl)
            begin
                kind_next    = 1'b1;
                byte_next    = 8'h00;
                last_next    = 1'b1;
                tgt_next     = job_reg.tgt;
                size_next    = job_reg.size;
                job_next.cpl = 1'b0;
                // tbox completion ends the answer
                if (job_reg.resp == RESP_NONE)
                begin
                    busy_next = 1'b0;
                end
            end
            else
            begin
                kind_next = 1'b0;
                byte_next = resp_byte(job_reg.resp, idx_reg, job_reg.sel);
                last_next = (idx_reg == resp_last_idx(job_reg.resp));
                tgt_next  = 1'b0;
                size_next = 32'd0;
                if (idx_reg == resp_last_idx(job_reg.resp))
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            job_reg       <= '0;
            idx_reg       <= 3'd0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            job_reg       <= job_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
        tgt_reg  <= tgt_next;
        size_reg <= size_next;
    end

    assign busy         = busy_reg;
    assign out_valid    = out_valid_reg;
    assign result_kind  = kind_reg;
    assign tx_byte      = byte_reg;
    assign tx_last      = last_reg;
    assign image_target = tgt_reg;
    assign image_size   = size_reg;

endmodule

@@ sim/upgrade_frame_handler_test.sv @@
// self-checking testbench for the upgrade frame handler: directed table, random frames
`timescale 1ns / 1ps

module upgrade_frame_handler_test;

    import ufh_pkg::*;

    localparam int RANDOM_ITEMS  = 175;
    localparam int STALL_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = 30;
    localparam int LONG_HOLD     = 200;
    localparam int FRAME_MAX     = 16;

    // commands outside the handled set
    localparam logic [7:0] CMD_NONE = 8'h00;
    localparam logic [7:0] CMD_BAD  = 8'h07;

    // first byte of each answer frame
    localparam logic [7:0] ANS_INFO = 8'h12;
    localparam logic [7:0] ANS_DATA = 8'h13;
    localparam logic [7:0] ANS_CMD4 = 8'h14;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_DONE = 1'b1;
    localparam logic OUT_TBOX  = 1'b0;
    localparam logic OUT_MCU   = 1'b1;

    localparam logic [7:0] INFO_ANSWER [7] = '{ANS_INFO, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h13};
    localparam logic [7:0] CMD4_ANSWER [6] = '{ANS_CMD4, 8'h00, 8'h00, 8'h00, 8'h01, 8'h15};

    typedef enum logic [2:0]
    {
        ROW_MODEL,
        ROW_QUIET,
        ROW_INFO,
        ROW_CMD4,
        ROW_TBOX_DONE
    } row_check_t;

    typedef struct packed
    {
        logic [7:0]  value;
        logic        last;
        row_check_t  check;
        logic [31:0] size;
    } stim_row_t;

    typedef struct
    {
        logic        kind;
        logic [7:0]  tx;
        logic        last;
        logic        tgt;
        logic [31:0] size;
    } upgrade_result_t;

    localparam int N_DIRECTED = 32;

    // typed rows carry their answer; model rows go through the frame predictor
    stim_row_t directed_rows [N_DIRECTED] = '{
        // one-byte frame of zero: command 0, no answer
        '{CMD_NONE, 1'b1, ROW_QUIET, 32'h0},
        '{CMD_CMD4, 1'b0, ROW_MODEL, 32'h0},
        '{CMD_CMD4, 1'b1, ROW_CMD4, 32'h0},
        // bad checksum
        '{CMD_BAD, 1'b1, ROW_QUIET, 32'h0},
        // data to tbox, length 2: total 0 equals size 0 right after reset
        '{CMD_DATA, 1'b0, ROW_MODEL, 32'h0},
        '{8'h00, 1'b0, ROW_MODEL, 32'h0},
        '{8'h00, 1'b0, ROW_MODEL, 32'h0},
        '{8'h00, 1'b0, ROW_MODEL, 32'h0},
        '{8'h02, 1'b0, ROW_MODEL, 32'h0},
        '{TGT_TBOX, 1'b0, ROW_MODEL, 32'h0},
        '{8'h00, 1'b1, ROW_TBOX_DONE, 32'h0},
        // data to mcu, length 2: completion followed by the data answer
        '{CMD_DATA, 1'b0, ROW_MODEL, 32'h0},
        '{8'h00, 1'b0, ROW_MODEL, 32'h0},
        '{8'h00, 1'b0, ROW_MODEL, 32'h0},
        '{8'h00, 1'b0, ROW_MODEL, 32'h0},
        '{8'h02, 1'b0, ROW_MODEL, 32'h0},
        '{TGT_MCU, 1'b0, ROW_MODEL, 32'h0},
        '{8'h03, 1'b1, ROW_MODEL, 32'h0},
        // data with unknown target in a short frame
        '{CMD_DATA, 1'b0, ROW_MODEL, 32'h0},
        '{8'h03, 1'b1, ROW_MODEL, 32'h0},
        // info to tbox with the largest size
        '{CMD_INFO, 1'b0, ROW_MODEL, 32'h0},
        '{8'h00, 1'b0, ROW_MODEL, 32'h0},
        '{8'h00, 1'b0, ROW_MODEL, 32'h0},
        '{8'h00, 1'b0, ROW_MODEL, 32'h0},
        '{8'h00, 1'b0, ROW_MODEL, 32'h0},
        '{TGT_TBOX, 1'b0, ROW_MODEL, 32'h0},
        '{8'hFF, 1'b0, ROW_MODEL, 32'h0},
        '{8'hFF, 1'b0, ROW_MODEL, 32'h0},
        '{8'hFF, 1'b0, ROW_MODEL, 32'h0},
        '{8'hFF, 1'b0, ROW_MODEL, 32'h0},
        '{8'h5A, 1'b0, ROW_MODEL, 32'h0},
        '{8'h59, 1'b1, ROW_INFO, 32'h0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        rx_last = 1'b0;
    logic        out_valid;
    logic        out_stall;
    logic        result_kind;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic        image_target;
    logic [31:0] image_size;

    logic recv_stall = 1'b0;
    logic long_hold = 1'b0;
    bit   send_burst = 1'b0;
    bit   recv_burst = 1'b0;
    int   random_frames = 0;
    int   mismatch_count = 0;
    int   quiet_cycles = 0;

    // frame predictor state
    logic [3:0]  hdr_pos = 4'd0;
    logic [7:0]  frame_xor = 8'h00;
    logic [7:0]  hdr [HDR_LEN] = '{default: 8'h00};
    logic [31:0] tbox_size = 32'h0;
    logic [31:0] mcu_size = 32'h0;
    logic [7:0]  tbox_sum = 8'h00;
    logic [7:0]  mcu_sum = 8'h00;
    logic [31:0] rx_total = 32'h0;

    upgrade_result_t predicted_q [$];
    upgrade_result_t expected_results [$];
    logic [7:0]      frame_buf [FRAME_MAX];

    assign out_stall = recv_stall | long_hold;

    upgrade_frame_handler dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .rx_last      (rx_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .tx_byte      (tx_byte),
        .tx_last      (tx_last),
        .image_target (image_target),
        .image_size   (image_size)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic logic [31:0] header_word(input int p);
        return {hdr[p], hdr[p + 1], hdr[p + 2], hdr[p + 3]};
    endfunction

    task automatic add_answer_byte(input logic [7:0] value, input logic last);
        upgrade_result_t r;
        r.kind = KIND_BYTE;
        r.tx   = value;
        r.last = last;
        r.tgt  = OUT_TBOX;
        r.size = 32'h0;
        predicted_q.push_back(r);
    endtask

    task automatic add_completion(input logic tgt, input logic [31:0] size);
        upgrade_result_t r;
        r.kind = KIND_DONE;
        r.tx   = 8'h00;
        r.last = 1'b1;
        r.tgt  = tgt;
        r.size = size;
        predicted_q.push_back(r);
    endtask

    task automatic add_info_answer();
        for (int i = 0; i < 7; i++)
            add_answer_byte(INFO_ANSWER[i], i == 6);
    endtask

    task automatic add_cmd4_answer();
        for (int i = 0; i < 6; i++)
            add_answer_byte(CMD4_ANSWER[i], i == 5);
    endtask

    // one accepted byte through the frame predictor; answers land in predicted_q
    task automatic predict_byte(input logic [7:0] value, input logic last);
        bit tbox_done;
        logic [7:0] sel;
        tbox_done = 1'b0;
        if (hdr_pos < HDR_LEN)
        begin
            hdr[hdr_pos] = value;
            hdr_pos++;
        end
        frame_xor ^= value;
        if (last)
        begin
            if (frame_xor == 8'h00)
            begin
                case (hdr[0])
                    CMD_INFO:
                    begin
                        if (hdr[5] == TGT_TBOX)
                        begin
                            tbox_size = header_word(6);
                            tbox_sum  = hdr[10];
                        end
                        else if (hdr[5] == TGT_MCU)
                        begin
                            mcu_size = header_word(6);
                            mcu_sum  = hdr[10];
                        end
                        add_info_answer();
                    end
                    CMD_DATA:
                    begin
                        if (hdr[5] == TGT_TBOX || hdr[5] == TGT_MCU)
                        begin
                            rx_total = rx_total + header_word(1) - 32'd2;
                            if (hdr[5] == TGT_TBOX && rx_total == tbox_size)
                            begin
                                add_completion(OUT_TBOX, tbox_size);
                                tbox_done = 1'b1;
                            end
                            else if (hdr[5] == TGT_MCU && rx_total == mcu_size)
                                add_completion(OUT_MCU, mcu_size);
                        end
                        // a finished tbox image ends the answer early
                        if (!tbox_done)
                        begin
                            sel = hdr[6];
                            add_answer_byte(ANS_DATA, 1'b0);
                            add_answer_byte(8'h00, 1'b0);
                            add_answer_byte(8'h00, 1'b0);
                            add_answer_byte(8'h00, 1'b0);
                            add_answer_byte(8'h02, 1'b0);
                            add_answer_byte(8'h00, 1'b0);
                            add_answer_byte(sel, 1'b0);
                            add_answer_byte(sel ^ 8'h11, 1'b1);
                        end
                    end
                    CMD_CMD4:
                        add_cmd4_answer();
                    default:
                        ;
                endcase
            end
            hdr_pos   = 4'd0;
            frame_xor = 8'h00;
            for (int i = 0; i < HDR_LEN; i++)
                hdr[i] = 8'h00;
        end
    endtask

    task automatic send_byte(input logic [7:0] value, input logic last,
                             input row_check_t check, input logic [31:0] done_size);
        int gap;
        if ($urandom_range(0, 15) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= value;
        rx_last  <= last;
        do
            @(posedge clk);
        while (in_stall);
        predict_byte(value, last);
        if (check != ROW_MODEL)
        begin
            predicted_q.delete();
            case (check)
                ROW_INFO:      add_info_answer();
                ROW_CMD4:      add_cmd4_answer();
                ROW_TBOX_DONE: add_completion(OUT_TBOX, done_size);
                default:       ;
            endcase
        end
        while (predicted_q.size() > 0)
            expected_results.push_back(predicted_q.pop_front());
    endtask

    function automatic logic [7:0] pick_target();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return TGT_TBOX;
        else if (r < 8)
            return TGT_MCU;
        return 8'($urandom);
    endfunction

    // builds one frame with a fitting checksum (or a broken one) and sends it
    task automatic send_random_frame(output int counted);
        int pick;
        int n;
        int r;
        bit broken;
        logic [7:0]  tgt;
        logic [7:0]  cks;
        logic [31:0] len;
        logic [31:0] size;
        for (int i = 0; i < FRAME_MAX; i++)
            frame_buf[i] = 8'($urandom);
        pick = $urandom_range(0, 99);
        broken = 1'b0;
        if (pick < 30)
        begin
            tgt = pick_target();
            if ($urandom_range(0, 3) == 0)
                size = $urandom;
            else
                size = rx_total + $urandom_range(0, 2000);
            frame_buf[0] = CMD_INFO;
            frame_buf[5] = tgt;
            {frame_buf[6], frame_buf[7], frame_buf[8], frame_buf[9]} = size;
            n = $urandom_range(11, FRAME_MAX - 1);
        end
        else if (pick < 70)
        begin
            tgt = pick_target();
            size = (tgt == TGT_MCU) ? mcu_size : tbox_size;
            r = $urandom_range(0, 9);
            // half the data frames land exactly on the declared size
            if (r < 5)
                len = size - rx_total + 32'd2;
            else if (r < 8)
                len = $urandom_range(2, 1500);
            else
                len = $urandom;
            frame_buf[0] = CMD_DATA;
            frame_buf[5] = tgt;
            {frame_buf[1], frame_buf[2], frame_buf[3], frame_buf[4]} = len;
            n = $urandom_range(7, FRAME_MAX);
        end
        else if (pick < 80)
        begin
            frame_buf[0] = CMD_CMD4;
            n = $urandom_range(2, 13);
        end
        else if (pick < 90)
        begin
            if ($urandom_range(0, 1) == 0)
                frame_buf[0] = 8'($urandom_range(0, 7));
            n = $urandom_range(1, 13);
        end
        else
        begin
            frame_buf[0] = 8'($urandom_range(CMD_INFO, CMD_CMD4));
            frame_buf[5] = pick_target();
            n = $urandom_range(1, FRAME_MAX);
            broken = 1'b1;
        end
        cks = 8'h00;
        for (int i = 0; i < n - 1; i++)
            cks ^= frame_buf[i];
        if (broken)
            cks ^= 8'($urandom_range(1, 255));
        frame_buf[n - 1] = cks;
        for (int i = 0; i < n; i++)
            send_byte(frame_buf[i], i == n - 1, ROW_MODEL, 32'h0);
        counted = n;
    endtask

    // result side: per-transfer stall draw, with calm stretches now and then
    initial
    begin : receiver
        int hold;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                recv_burst = !recv_burst;
            hold = recv_burst ? 0 : $urandom_range(0, 19);
            if (hold > 0)
            begin
                recv_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            recv_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    // long hold-off on the result side so the block backs up into its input
    initial
    begin : backpressure
        wait (random_frames >= 6);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold <= 1'b0;
    end

    always @(posedge clk)
    begin : result_check
        upgrade_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with nothing pending, tx_byte", tx_byte, 32'h0);
            else
            begin
                want = expected_results.pop_front();
                if (result_kind !== want.kind)
                    report_mismatch("result_kind", result_kind, want.kind);
                if (tx_byte !== want.tx)
                    report_mismatch("tx_byte", tx_byte, want.tx);
                if (tx_last !== want.last)
                    report_mismatch("tx_last", tx_last, want.last);
                if (image_target !== want.tgt)
                    report_mismatch("image_target", image_target, want.tgt);
                if (image_size !== want.size)
                    report_mismatch("image_size", image_size, want.size);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin : main
        int useful;
        int counted;
        useful = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < N_DIRECTED; i++)
            send_byte(directed_rows[i].value, directed_rows[i].last,
                      directed_rows[i].check, directed_rows[i].size);
        while (useful < RANDOM_ITEMS)
        begin
            send_random_frame(counted);
            useful += counted;
            random_frames++;
        end
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
